// ----- rtl/emulated_eeprom_access_gate_core_assert.svh -----
// assertion macros for the emulated eeprom access gate
`ifndef EMULATED_EEPROM_ACCESS_GATE_CORE_ASSERT_SVH
`define EMULATED_EEPROM_ACCESS_GATE_CORE_ASSERT_SVH

// same-cycle implication
`define EEAG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EEAG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/eeag_pkg.sv -----
// package: constants, types and helpers of the emulated eeprom access gate
`timescale 1ns / 1ps

package eeag_pkg;

    localparam int PAGE_USABLE_BYTES = 1022;
    localparam int PAGE_BYTES        = 1024;
    localparam int MAX_PAGES         = 8;
    localparam int STORE_BYTES       = MAX_PAGES * PAGE_BYTES;
    localparam int WORD_BYTES        = 4;

    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 32;
    localparam int MEM_AW  = $clog2(STORE_BYTES);
    localparam int OFF_W   = $clog2(PAGE_BYTES);
    localparam int PAGE_W  = $clog2(MAX_PAGES);
    localparam int LANE_W  = $clog2(WORD_BYTES);
    localparam int SIZE_W  = 2;
    localparam int CIDX_W  = 1;
    localparam int CDATA_W = 2;

    localparam logic [CIDX_W-1:0] REG_ENABLE = 1'b0;
    localparam logic [CIDX_W-1:0] REG_SIZE   = 1'b1;

    typedef enum logic [1:0] {
        OP_RD_BYTE = 2'd0,
        OP_WR_BYTE = 2'd1,
        OP_RD_WORD = 2'd2,
        OP_WR_WORD = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ACC,
        ST_LAST,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_req;

    function automatic logic [ADDR_W-1:0] log_size(input logic en, input logic [SIZE_W-1:0] code);
        return en ? (ADDR_W'(PAGE_USABLE_BYTES) << code) : '0;
    endfunction

    function automatic logic [ADDR_W:0] phys_size(input logic en, input logic [SIZE_W-1:0] code);
        return en ? ((ADDR_W+1)'(PAGE_BYTES) << code) : '0;
    endfunction

endpackage

// ----- rtl/eeag_if.sv -----
// channel interfaces: access input, result output and register write
`timescale 1ns / 1ps

interface eeag_in_if import eeag_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [ADDR_W-1:0] address;
    logic              real_mode;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, operation, address, real_mode, write_data, input ready);
    modport sink   (input valid, operation, address, real_mode, write_data, output ready);
endinterface

interface eeag_out_if import eeag_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              accepted;

    modport source (output valid, read_data, accepted, input ready);
    modport sink   (input valid, read_data, accepted, output ready);
endinterface

interface eeag_cfg_if import eeag_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CIDX_W-1:0]  index;
    logic [CDATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/eeag_store.sv -----
// byte-wide backing store with erase sweep after reset
`timescale 1ns / 1ps

module eeag_store import eeag_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_mem_req   i_req,
    output logic [7:0] o_rdata,
    output logic       o_busy
);

    logic [7:0]        r_mem [STORE_BYTES];
    logic [MEM_AW-1:0] r_clr_addr;
    logic [MEM_AW-1:0] n_clr_addr;
    logic              r_clearing;
    logic              n_clearing;
    logic [7:0]        r_q;
    logic              w_we;
    logic [MEM_AW-1:0] w_waddr;
    logic [7:0]        w_wdata;

    always_comb begin
        n_clr_addr = r_clr_addr;
        n_clearing = r_clearing;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == MEM_AW'(STORE_BYTES - 1)) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
        end
    end

    // erase sweep writes 0xff
    assign w_we    = r_clearing || (i_req.en && i_req.we);
    assign w_waddr = r_clearing ? r_clr_addr : i_req.addr;
    assign w_wdata = r_clearing ? 8'hFF : i_req.wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en && !i_req.we) begin
            r_q <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_q;
    assign o_busy  = r_clearing;

endmodule

// ----- rtl/emulated_eeprom_access_gate_core.sv -----
// top level: address checks, page mapping sequencer and result register
//
// channel   dir   word
// i_in      in    operation, address, real_mode, write_data
// o_out     out   read_data, accepted
// i_cfg     in    index (0 enable, 1 size code), data
//
// accept to result: a real byte passes ST_ACC, ST_LAST and ST_FIN, a logical
// byte walks ST_DIV first, a word does so with four ST_ACC steps, a rejected
// access goes straight to ST_FIN; the page search subtracts 1022 once a cycle;
// the byte store has one port, so a word is accessed one byte per cycle
// after reset the store is erased in a sweep; no word is taken then
// a finished result waits in the output register while the next word is taken

`timescale 1ns / 1ps
`include "emulated_eeprom_access_gate_core_assert.svh"

module emulated_eeprom_access_gate_core import eeag_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    eeag_in_if.sink     i_in,
    eeag_out_if.source  o_out,
    eeag_cfg_if.sink    i_cfg
);

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [DATA_W-1:0]   r_data, n_data;
    logic                r_ok, n_ok;
    logic [MEM_AW-1:0]   r_rem, n_rem;
    logic [PAGE_W-1:0]   r_page, n_page;
    logic [LANE_W-1:0]   r_lane, n_lane;
    logic [LANE_W-1:0]   r_lane_last, n_lane_last;
    logic [DATA_W-1:0]   r_rdata, n_rdata;
    logic                r_rd_pend, n_rd_pend;
    logic [LANE_W-1:0]   r_rd_lane, n_rd_lane;
    logic                r_enable, n_enable;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_data, n_out_data;
    logic                r_out_acc, n_out_acc;

    t_mem_req            w_req;
    logic [7:0]          w_mem_q;
    logic                w_store_busy;
    logic                w_in_take;
    t_op                 w_in_op;
    logic [ADDR_W-1:0]   w_lsize;
    logic [ADDR_W:0]     w_psize;
    logic                w_chk;
    logic [MEM_AW:0]     w_sub;
    logic [MEM_AW-1:0]   w_off_inc;
    logic                w_is_write;

    eeag_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rdata (w_mem_q),
        .o_busy  (w_store_busy)
    );

    assign i_in.ready      = (r_state == ST_IDLE) && !w_store_busy;
    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_out_data;
    assign o_out.accepted  = r_out_acc;

    assign w_in_take = i_in.valid && i_in.ready;
    assign w_in_op   = t_op'(i_in.operation);
    assign w_lsize   = log_size(r_enable, r_size);
    assign w_psize   = phys_size(r_enable, r_size);
    assign w_sub     = {1'b0, r_rem} - (MEM_AW+1)'(PAGE_USABLE_BYTES);
    assign w_off_inc = r_rem + 1'b1;
    assign w_is_write = (r_op == OP_WR_BYTE) || (r_op == OP_WR_WORD);

    // address checks
    always_comb begin
        case (w_in_op)
            OP_RD_BYTE, OP_WR_BYTE: begin
                if (i_in.real_mode) begin
                    w_chk = ({1'b0, i_in.address} < w_psize)
                        && (i_in.address[OFF_W-1:0] < OFF_W'(PAGE_USABLE_BYTES));
                end else begin
                    w_chk = i_in.address < w_lsize;
                end
            end
            OP_RD_WORD, OP_WR_WORD: begin
                w_chk = (i_in.address[LANE_W-1:0] == '0)
                    && (({1'b0, i_in.address} + (ADDR_W+1)'(WORD_BYTES))
                        <= {1'b0, w_lsize});
            end
            default: w_chk = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_data      = r_data;
        n_ok        = r_ok;
        n_rem       = r_rem;
        n_page      = r_page;
        n_lane      = r_lane;
        n_lane_last = r_lane_last;
        n_rdata     = r_rdata;
        n_rd_pend   = 1'b0;
        n_rd_lane   = r_lane;
        n_enable    = r_enable;
        n_size      = r_size;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_acc   = r_out_acc;

        w_req.en    = 1'b0;
        w_req.we    = 1'b0;
        w_req.addr  = {r_page, r_rem[OFF_W-1:0]};
        w_req.wdata = 8'(r_data >> {r_lane, 3'b000});

        if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_ENABLE: n_enable = i_cfg.data[0];
                REG_SIZE:   n_size   = i_cfg.data[SIZE_W-1:0];
                default:    ;
            endcase
        end

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (r_rd_pend) begin
            n_rdata = r_rdata | (DATA_W'(w_mem_q) << {r_rd_lane, 3'b000});
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_take) begin
                    n_op        = w_in_op;
                    n_data      = i_in.write_data;
                    n_ok        = w_chk;
                    n_rdata     = '0;
                    n_lane      = '0;
                    n_lane_last = (w_in_op == OP_RD_WORD || w_in_op == OP_WR_WORD)
                        ? LANE_W'(WORD_BYTES - 1) : '0;
                    n_rem       = i_in.address[MEM_AW-1:0];
                    n_page      = '0;
                    if (!w_chk) begin
                        n_state = ST_FIN;
                    end else if ((w_in_op == OP_RD_BYTE || w_in_op == OP_WR_BYTE)
                            && i_in.real_mode) begin
                        n_rem   = MEM_AW'(i_in.address[OFF_W-1:0]);
                        n_page  = i_in.address[MEM_AW-1:OFF_W];
                        n_state = ST_ACC;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                // one page per cycle through the subtractor
                if (!w_sub[MEM_AW]) begin
                    n_rem  = w_sub[MEM_AW-1:0];
                    n_page = r_page + 1'b1;
                end else begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                w_req.en  = 1'b1;
                w_req.we  = w_is_write;
                n_rd_pend = !w_is_write;
                n_rd_lane = r_lane;
                // step past the page hole
                if (w_off_inc == MEM_AW'(PAGE_USABLE_BYTES)) begin
                    n_rem  = '0;
                    n_page = r_page + 1'b1;
                end else begin
                    n_rem = w_off_inc;
                end
                if (r_lane == r_lane_last) begin
                    n_state = ST_LAST;
                end else begin
                    n_lane = r_lane + 1'b1;
                end
            end
            ST_LAST: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_rdata;
                    n_out_acc   = r_ok;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_pend   <= 1'b0;
            r_enable    <= 1'b1;
            r_size      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_pend   <= n_rd_pend;
            r_enable    <= n_enable;
            r_size      <= n_size;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_data      <= n_data;
        r_ok        <= n_ok;
        r_rem       <= n_rem;
        r_page      <= n_page;
        r_lane      <= n_lane;
        r_lane_last <= n_lane_last;
        r_rdata     <= n_rdata;
        r_rd_lane   <= n_rd_lane;
        r_out_data  <= n_out_data;
        r_out_acc   <= n_out_acc;
    end

    `EEAG_ASSERT_IMP(a_reject_zero, i_clk, i_rst_n, o_out.valid && !o_out.accepted, o_out.read_data == '0, "rejected access returned data")
    `EEAG_ASSERT_IMP(a_no_take_in_erase, i_clk, i_rst_n, w_store_busy, !i_in.ready, "access taken during erase sweep")
    `EEAG_ASSERT_IMP(a_no_hole, i_clk, i_rst_n, r_state == ST_ACC, r_rem < MEM_AW'(PAGE_USABLE_BYTES), "store access inside page hole")
    `EEAG_ASSERT_NEXT(a_fin_delivers, i_clk, i_rst_n, r_state == ST_FIN && (!r_out_valid || o_out.ready), r_out_valid && r_state == ST_IDLE, "finished access not delivered")

endmodule
